/* design/assert_macros.svh */
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is high.
`define SSS_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SSS_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/sss_pkg.sv */
// Types and constants of the sorted set store.
package sss_pkg;

  localparam int CAPACITY_DEFAULT = 64;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_NONE   = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SCAN_CHK,
    S_SHIFT_START,
    S_SHIFT,
    S_SHIFT_WR,
    S_POP_DONE
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC,
    IDX_DEC,
    IDX_COUNT
  } idx_op_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_CNT_M1
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_KEY
  } wr_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_KEY,
    RES_RDATA
  } res_sel_t;

  typedef struct packed {
    logic     load;
    idx_op_t  idx_op;
    logic     pos_load;
    logic     rd_en;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    logic     count_inc;
    logic     count_dec;
    logic     emit;
    status_t  emit_status;
    res_sel_t res_sel;
  } dp_cmd_t;

  typedef struct packed {
    act_t act;
    logic full;
    logic empty;
    logic idx_lt_count;
    logic idx_gt_pos;
    logic rd_lt_key;
    logic rd_eq_key;
  } dp_stat_t;

endpackage

/* design/sss_dp.sv */
// Datapath of the sorted set store: entry memory, pointers, count and result registers.
module sss_dp import sss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [1:0]         action,
  input  logic signed [31:0] operand_value,
  output dp_stat_t           stat,
  output logic               done,
  output logic [2:0]         status,
  output logic signed [31:0] result_value,
  output logic [6:0]         entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata;
  logic signed [31:0] key;
  act_t               act;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      idx_next;
  logic [CW-1:0]      idx_m1;
  logic [CW-1:0]      cnt_m1;
  logic [CW-1:0]      pos;
  logic [AW-1:0]      rd_addr;

  assign idx_m1 = idx - CW'(1);
  assign cnt_m1 = count - CW'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:    rd_addr = idx[AW-1:0];
      RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
      RD_CNT_M1: rd_addr = cnt_m1[AW-1:0];
      default:   rd_addr = idx[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
    case (cmd.wr_sel)
      WR_SHIFT: mem[idx[AW-1:0]] <= rdata;
      WR_KEY:   mem[idx[AW-1:0]] <= key;
      default: ;
    endcase
  end

  always_comb begin
    case (cmd.idx_op)
      IDX_CLR:   idx_next = '0;
      IDX_INC:   idx_next = idx + CW'(1);
      IDX_DEC:   idx_next = idx_m1;
      IDX_COUNT: idx_next = count;
      default:   idx_next = idx;
    endcase
  end

  always_comb begin
    if (cmd.count_inc) begin
      count_next = count + CW'(1);
    end else if (cmd.count_dec) begin
      count_next = cnt_m1;
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.load) begin
      key <= operand_value;
      act <= act_t'(action);
    end
    if (cmd.pos_load) begin
      pos <= idx;
    end
    if (cmd.emit) begin
      status      <= cmd.emit_status;
      entry_count <= 7'(count_next);
      case (cmd.res_sel)
        RES_KEY:   result_value <= key;
        RES_RDATA: result_value <= rdata;
        default:   result_value <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= cmd.emit;
    end
  end

  assign stat.act          = act;
  assign stat.full         = (count == CW'(CAPACITY));
  assign stat.empty        = (count == '0);
  assign stat.idx_lt_count = (idx < count);
  assign stat.idx_gt_pos   = (idx > pos);
  assign stat.rd_lt_key    = (rdata < key);
  assign stat.rd_eq_key    = (rdata == key);

endmodule

/* design/sss_ctrl.sv */
// Controller of the sorted set store: sequences scan, shift and pop over the entry memory.
module sss_ctrl import sss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.act)
          ACT_INSERT: state_next = stat.full ? S_IDLE : S_SCAN;
          ACT_REMOVE: state_next = stat.empty ? S_IDLE : S_POP_DONE;
          ACT_SEARCH: state_next = S_SCAN;
          default:    state_next = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (stat.idx_lt_count) begin
          state_next = S_SCAN_CHK;
        end else if (stat.act == ACT_INSERT) begin
          state_next = S_SHIFT_START;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN_CHK: begin
        if (stat.rd_lt_key) begin
          state_next = S_SCAN;
        end else if (!stat.rd_eq_key && stat.act == ACT_INSERT) begin
          state_next = S_SHIFT_START;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SHIFT_START: state_next = S_SHIFT;
      S_SHIFT: begin
        state_next = stat.idx_gt_pos ? S_SHIFT_WR : S_IDLE;
      end
      S_SHIFT_WR: state_next = S_SHIFT;
      S_POP_DONE: state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.idx_op      = IDX_HOLD;
    cmd.rd_sel      = RD_IDX;
    cmd.wr_sel      = WR_NONE;
    cmd.emit_status = ST_OK;
    cmd.res_sel     = RES_ZERO;
    busy            = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cmd.idx_op = IDX_CLR;
        end
      end
      S_DECODE: begin
        case (stat.act)
          ACT_INSERT: begin
            if (stat.full) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_FULL;
            end
          end
          ACT_REMOVE: begin
            if (stat.empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_EMPTY;
            end else begin
              cmd.rd_en     = 1'b1;
              cmd.rd_sel    = RD_CNT_M1;
              cmd.count_dec = 1'b1;
            end
          end
          ACT_SEARCH: ;
          default: cmd.emit = 1'b1;
        endcase
      end
      S_SCAN: begin
        if (stat.idx_lt_count) begin
          cmd.rd_en = 1'b1;
        end else if (stat.act != ACT_INSERT) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_NOTFOUND;
        end
      end
      S_SCAN_CHK: begin
        if (stat.rd_lt_key) begin
          cmd.idx_op = IDX_INC;
        end else if (stat.rd_eq_key) begin
          cmd.emit = 1'b1;
          if (stat.act == ACT_INSERT) begin
            cmd.emit_status = ST_DUP;
          end else begin
            cmd.res_sel = RES_KEY;
          end
        end else if (stat.act != ACT_INSERT) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_NOTFOUND;
        end
      end
      S_SHIFT_START: begin
        cmd.pos_load = 1'b1;
        cmd.idx_op   = IDX_COUNT;
      end
      S_SHIFT: begin
        if (stat.idx_gt_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
        end else begin
          // The gap has reached the sorted position: drop the new value in.
          cmd.wr_sel    = WR_KEY;
          cmd.count_inc = 1'b1;
          cmd.emit      = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_sel = WR_SHIFT;
        cmd.idx_op = IDX_DEC;
      end
      S_POP_DONE: begin
        cmd.emit    = 1'b1;
        cmd.res_sel = RES_RDATA;
      end
      default: ;
    endcase
  end

endmodule

/* design/sorted_set_store_top.sv */
// Top level of the sorted set store: controller and datapath.
//
//  channel   signals                              handshake
//  command   action, operand_value                start & !busy
//  result    status, result_value, entry_count    done, one cycle
//
// An unused code, a full insert or an empty remove finishes in the decode state; a remove
// reads the last entry and pops it. A search or insert scans each stored entry below its
// key, then checks the first entry not below the key if one exists. An insert that stores
// its value then shifts each larger entry up by one place and writes the value into the gap.
// done is high in the first cycle that busy is low; reset clears the count.
// The receiver cannot stall, so busy depends on the sequencer alone.
module sorted_set_store_top import sss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic signed [31:0] operand_value,
  output logic               done,
  output logic [2:0]         status,
  output logic signed [31:0] result_value,
  output logic [6:0]         entry_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  sss_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .action        (action),
    .operand_value (operand_value),
    .stat          (stat),
    .done          (done),
    .status        (status),
    .result_value  (result_value),
    .entry_count   (entry_count)
  );

endmodule

/* design/sss_checker.sv */
// Port-level checks of the sorted set store, bound to the top level.
`include "assert_macros.svh"

module sss_checker import sss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [2:0]         status,
  input logic signed [31:0] result_value,
  input logic [6:0]         entry_count
);

  `SSS_ASSERT(a_done_idle, clk, done |-> !busy, "result beat while busy")
  `SSS_ASSERT_RST(a_accept_busy, clk, rst, (start && !busy) |=> busy, "no busy after accept")
  `SSS_ASSERT_RST(a_full_count, clk, rst, (done && status == ST_FULL) |-> (entry_count == 7'(CAPACITY)), "full refusal with count below capacity")
  `SSS_ASSERT_RST(a_empty_zero, clk, rst, (done && status == ST_EMPTY) |-> (entry_count == 7'd0 && result_value == 32'sd0), "empty remove with nonzero count or value")

endmodule

bind sorted_set_store_top sss_checker #(.CAPACITY(CAPACITY)) u_sss_checker (.*);

/* tb/sorted_set_store_top_tb.sv */
// Self-checking testbench of the sorted set store with a scoreboard class.
module sorted_set_store_top_tb;
  import sss_pkg::*;

  localparam int CAP = CAPACITY_DEFAULT;
  localparam int RANDOM_ITEMS = 1200;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    status_t            status;
    logic signed [31:0] value;
    logic [6:0]         count;
  } set_reply_t;

  class set_scoreboard;
    logic signed [31:0] entries[CAP];
    int unsigned        count;
    set_reply_t         pending_replies[$];
    int                 errors;
    int                 checked;
    int                 status_seen[5];
    int                 peak_count;

    function new();
      count = 0;
      errors = 0;
      checked = 0;
      peak_count = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // First position whose entry is not below the key.
    function int first_not_below(logic signed [31:0] key);
      int pos;
      pos = 0;
      while (pos < count && entries[pos] < key) pos++;
      return pos;
    endfunction

    function logic signed [31:0] pick_stored();
      return entries[$urandom_range(0, count - 1)];
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    function void note_command(act_t act, logic signed [31:0] key);
      set_reply_t r;
      int pos;
      r.status = ST_OK;
      r.value = '0;
      case (act)
        ACT_INSERT: begin
          if (count >= CAP) begin
            r.status = ST_FULL;
          end else begin
            pos = first_not_below(key);
            if (pos < count && entries[pos] == key) begin
              r.status = ST_DUP;
            end else begin
              for (int j = count; j > pos; j--) entries[j] = entries[j - 1];
              entries[pos] = key;
              count++;
            end
          end
        end
        ACT_REMOVE: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            count--;
            r.value = entries[count];
          end
        end
        ACT_SEARCH: begin
          pos = first_not_below(key);
          if (pos < count && entries[pos] == key) r.value = key;
          else r.status = ST_NOTFOUND;
        end
        default: ;
      endcase
      r.count = count[6:0];
      if (count > peak_count) peak_count = count;
      status_seen[r.status]++;
      pending_replies.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic signed [31:0] val, logic [6:0] cnt);
      set_reply_t r;
      if (pending_replies.size() == 0) begin
        $error("unexpected result beat: status %0d result_value %0d entry_count %0d",
               st, val, cnt);
        errors++;
        return;
      end
      r = pending_replies.pop_front();
      checked++;
      if (st !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, st);
        errors++;
      end
      if (val !== r.value) begin
        $error("result_value: expected %0d, actual %0d", r.value, val);
        errors++;
      end
      if (cnt !== r.count) begin
        $error("entry_count: expected %0d, actual %0d", r.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         action = ACT_INSERT;
  logic signed [31:0] operand_value = '0;
  logic               busy;
  logic               done;
  logic [2:0]         status;
  logic signed [31:0] result_value;
  logic [6:0]         entry_count;

  set_scoreboard sb = new();
  int            n_sent = 0;
  int            idle_mode = 1;
  int            quiet_cycles = 0;

  sorted_set_store_top u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .operand_value (operand_value),
    .done          (done),
    .status        (status),
    .result_value  (result_value),
    .entry_count   (entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, result_value, entry_count);
  end

  // Ends a hung run: counts cycles with neither a command nor a result beat.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    case (idle_mode)
      0: return 0;
      1: return $urandom_range(0, 19);
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
    endcase
  endfunction

  task automatic send(act_t act, logic signed [31:0] key);
    int gap;
    start <= 1'b1;
    action <= act;
    operand_value <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(act, key);
    n_sent++;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds off the next command until every outstanding result beat is back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  function automatic logic signed [31:0] rand_value(int pct_stored, int pct_small);
    int r;
    logic signed [31:0] v;
    r = $urandom_range(0, 99);
    if (r < pct_stored && sb.count > 0) begin
      v = sb.pick_stored();
    end else if (r < pct_stored + pct_small) begin
      v = int'($urandom_range(0, 16)) - 8;
    end else if (r < pct_stored + pct_small + 4) begin
      case ($urandom_range(0, 3))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7fff_ffff;
        2: v = 32'sh0000_0000;
        default: v = -32'sd1;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  task automatic directed_part();
    send(ACT_SEARCH, 32'sd0);
    send(ACT_REMOVE, 32'sd0);
    send(ACT_NONE, -32'sd1);
    send(ACT_INSERT, 32'sd0);
    send(ACT_INSERT, 32'sh7fff_ffff);
    send(ACT_INSERT, 32'sh8000_0000);
    send(ACT_INSERT, -32'sd1);
    send(ACT_INSERT, 32'sd1);
    send(ACT_INSERT, 32'sd0);
    send(ACT_INSERT, 32'sh8000_0000);
    send(ACT_SEARCH, 32'sh7fff_ffff);
    send(ACT_SEARCH, 32'sh8000_0000);
    send(ACT_SEARCH, 32'sd2);
    send(ACT_SEARCH, -32'sd2);
    send(ACT_NONE, 32'sh5555_5555);
    send(ACT_REMOVE, 32'shaaaa_aaaa);
    send(ACT_SEARCH, 32'sh7fff_ffff);
    repeat (4) send(ACT_REMOVE, 32'sd0);
    send(ACT_REMOVE, 32'sd0);
    send(ACT_SEARCH, 32'sh8000_0000);
  endtask

  task automatic random_part();
    int kind;
    int len;
    int r;
    int done_items;
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 3);
      idle_mode = $urandom_range(0, 2);
      len = (kind == 0) ? $urandom_range(70, 110) : $urandom_range(20, 60);
      for (int i = 0; i < len && done_items < RANDOM_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        case (kind)
          // Fill: mostly fresh values, so the store reaches capacity.
          0: begin
            if (r < 88) send(ACT_INSERT, rand_value(8, 8));
            else if (r < 95) send(ACT_SEARCH, rand_value(60, 10));
            else send(ACT_REMOVE, $urandom);
          end
          // Drain down to the empty store and past it.
          1: begin
            if (r < 80) send(ACT_REMOVE, $urandom);
            else if (r < 92) send(ACT_SEARCH, rand_value(60, 10));
            else send(ACT_INSERT, rand_value(20, 20));
          end
          2: begin
            if (r < 40) send(ACT_INSERT, rand_value(20, 30));
            else if (r < 65) send(ACT_REMOVE, $urandom);
            else if (r < 95) send(ACT_SEARCH, rand_value(50, 20));
            else send(ACT_NONE, $urandom);
          end
          default: begin
            case ($urandom_range(0, 3))
              0: send(ACT_INSERT, rand_value(30, 30));
              1: send(ACT_REMOVE, $urandom);
              2: send(ACT_SEARCH, rand_value(30, 30));
              default: send(ACT_NONE, $urandom);
            endcase
          end
        endcase
        done_items++;
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_part();
    wait_drained();
    random_part();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Checked %0d result beats from %0d commands; peak store fill %0d of %0d.",
             sb.checked, n_sent, sb.peak_count, CAP);
    $display("Statuses seen: ok %0d, duplicate %0d, full %0d, empty %0d, not found %0d.",
             sb.status_seen[ST_OK], sb.status_seen[ST_DUP], sb.status_seen[ST_FULL],
             sb.status_seen[ST_EMPTY], sb.status_seen[ST_NOTFOUND]);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
